@@ src/mec_pkg.sv @@
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths, types and the color band ladder for the escape color unit.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int C_W         = 32;
  // z stays inside +/-12 while iterating; 5 integer bits with sign
  localparam int Z_W         = FRAC_BITS + 5;
  localparam int PROD_W      = 2 * Z_W;
  localparam int P_W         = PROD_W - FRAC_BITS;
  localparam int CNT_W       = 12;
  localparam int CLR_W       = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int BANDS       = 25;

  localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(2000);
  localparam logic signed [P_W:0] ESC_LIMIT = (P_W + 1)'(1) << (FRAC_BITS + 2);

  localparam logic [CLR_W-1:0] CLR_BLACK   = 3'd0;
  localparam logic [CLR_W-1:0] CLR_RED     = 3'd1;
  localparam logic [CLR_W-1:0] CLR_YELLOW  = 3'd2;
  localparam logic [CLR_W-1:0] CLR_GREEN   = 3'd3;
  localparam logic [CLR_W-1:0] CLR_BLUE    = 3'd4;
  localparam logic [CLR_W-1:0] CLR_MAGENTA = 3'd5;
  localparam logic [CLR_W-1:0] CLR_CYAN    = 3'd6;
  localparam logic [CLR_W-1:0] CLR_WHITE   = 3'd7;

  typedef logic [CNT_W-1:0] band_limit_t [BANDS];
  typedef logic [CLR_W-1:0] band_color_t [BANDS];

  localparam band_limit_t BAND_LIMIT = '{
    12'd5, 12'd10, 12'd15, 12'd20, 12'd30, 12'd40, 12'd50, 12'd100, 12'd200,
    12'd300, 12'd400, 12'd500, 12'd600, 12'd700, 12'd800, 12'd900, 12'd1000,
    12'd1100, 12'd1200, 12'd1300, 12'd1400, 12'd1500, 12'd1600, 12'd1700,
    12'd1800
  };

  localparam band_color_t BAND_COLOR = '{
    CLR_BLUE, CLR_RED, CLR_YELLOW, CLR_GREEN, CLR_CYAN, CLR_MAGENTA,
    CLR_BLUE, CLR_RED, CLR_YELLOW, CLR_GREEN, CLR_CYAN, CLR_MAGENTA,
    CLR_BLUE, CLR_RED, CLR_YELLOW, CLR_GREEN, CLR_CYAN, CLR_MAGENTA,
    CLR_BLUE, CLR_RED, CLR_YELLOW, CLR_GREEN, CLR_CYAN, CLR_MAGENTA,
    CLR_WHITE
  };

  typedef struct packed {
    logic signed [C_W-1:0] c_re;
    logic signed [C_W-1:0] c_im;
    logic                  skip;
  } work_t;

  // first threshold above n wins; past the last one is black
  function automatic logic [CLR_W-1:0] band_color(input logic [CNT_W-1:0] n);
    logic [CLR_W-1:0] clr;
    clr = CLR_BLACK;
    for (int i = BANDS - 1; i >= 0; i--) begin
      if (n < BAND_LIMIT[i]) begin
        clr = BAND_COLOR[i];
      end
    end
    return clr;
  endfunction

endpackage

@@ src/mec_front.sv @@
// ----------------------------------------------------------------------------
// mec_front
// Input stage: holds the iteration limit, takes words and tags trivial ones.
// ----------------------------------------------------------------------------
module mec_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [mec_pkg::C_W-1:0]        c_re,
  input  logic signed [mec_pkg::C_W-1:0]        c_im,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [mec_pkg::CNT_W-1:0]      cfg_data,
  output logic        [mec_pkg::CNT_W-1:0]      max_iterations,
  output logic                                  work_valid,
  input  logic                                  work_full,
  output mec_pkg::work_t                        work
);

  logic hold_valid;

  assign full       = hold_valid;
  assign cfg_ready  = 1'b1;
  assign work_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mec_pkg::MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_iterations <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (push && !hold_valid) begin
      hold_valid <= 1'b1;
    end else if (hold_valid && !work_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !hold_valid) begin
      work.c_re <= c_re;
      work.c_im <= c_im;
      work.skip <= (max_iterations == '0);
    end
  end

endmodule

@@ src/mec_queue.sv @@
// ----------------------------------------------------------------------------
// mec_queue
// Short work queue between the input stage and the iteration engine.
// ----------------------------------------------------------------------------
module mec_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  output logic           q_full,
  input  mec_pkg::work_t wr_data,
  input  logic           rd_en,
  output logic           q_empty,
  output mec_pkg::work_t rd_data
);

  mec_pkg::work_t              mem [mec_pkg::QUEUE_DEPTH];
  logic [mec_pkg::QA_W-1:0]    wr_ptr;
  logic [mec_pkg::QA_W-1:0]    rd_ptr;
  logic [mec_pkg::QA_W:0]      count;
  logic                        do_wr;
  logic                        do_rd;

  assign q_full  = (count == (mec_pkg::QA_W + 1)'(mec_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/mec_core.sv @@
// ----------------------------------------------------------------------------
// mec_core
// Iteration engine: z = z^2 + c via multiply/add states, plus the result word.
// ----------------------------------------------------------------------------
module mec_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mec_pkg::CNT_W-1:0]         max_iterations,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  mec_pkg::work_t                    work,
  output logic                              empty,
  input  logic                              pop,
  output logic [mec_pkg::CLR_W-1:0]         color_code,
  output logic [mec_pkg::CNT_W-1:0]         iteration_count
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_FIN} state_t;

  state_t                              state;
  logic signed [mec_pkg::C_W-1:0]      cr;
  logic signed [mec_pkg::C_W-1:0]      ci;
  logic signed [mec_pkg::Z_W-1:0]      x;
  logic signed [mec_pkg::Z_W-1:0]      y;
  logic signed [mec_pkg::P_W-1:0]      xx;
  logic signed [mec_pkg::P_W-1:0]      yy;
  logic signed [mec_pkg::P_W-1:0]      xy2;
  logic        [mec_pkg::CNT_W-1:0]    n;
  logic                                res_valid;

  logic signed [mec_pkg::PROD_W-1:0]   pxx;
  logic signed [mec_pkg::PROD_W-1:0]   pyy;
  logic signed [mec_pkg::PROD_W-1:0]   pxy;
  logic signed [mec_pkg::P_W:0]        mag;
  logic signed [mec_pkg::P_W-1:0]      cr_ext;
  logic signed [mec_pkg::P_W-1:0]      ci_ext;
  logic signed [mec_pkg::P_W-1:0]      x_sum;
  logic signed [mec_pkg::P_W-1:0]      y_sum;

  assign pxx    = x * x;
  assign pyy    = y * y;
  assign pxy    = x * y;
  assign mag    = {xx[mec_pkg::P_W-1], xx} + {yy[mec_pkg::P_W-1], yy};
  assign cr_ext = {{(mec_pkg::P_W - mec_pkg::C_W){cr[mec_pkg::C_W-1]}}, cr};
  assign ci_ext = {{(mec_pkg::P_W - mec_pkg::C_W){ci[mec_pkg::C_W-1]}}, ci};
  assign x_sum  = xx - yy + cr_ext;
  assign y_sum  = xy2 + ci_ext;

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign empty  = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!res_valid || pop)) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cr    <= work.c_re;
            ci    <= work.c_im;
            x     <= '0;
            y     <= '0;
            n     <= '0;
            state <= work.skip ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          if (n == max_iterations) begin
            state <= S_FIN;
          end else begin
            // floor of the scaled product is an arithmetic shift
            xx    <= mec_pkg::P_W'(pxx >>> mec_pkg::FRAC_BITS);
            yy    <= mec_pkg::P_W'(pyy >>> mec_pkg::FRAC_BITS);
            xy2   <= mec_pkg::P_W'(pxy >>> (mec_pkg::FRAC_BITS - 1));
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (mag >= mec_pkg::ESC_LIMIT) begin
            state <= S_FIN;
          end else begin
            x     <= x_sum[mec_pkg::Z_W-1:0];
            y     <= y_sum[mec_pkg::Z_W-1:0];
            n     <= n + 1'b1;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          if (!res_valid || pop) begin
            iteration_count <= n;
            color_code      <= mec_pkg::band_color(n);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_ADD) |-> (n <= max_iterations))
    else $error("iteration count passed the limit");

  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_valid && !pop) |=> (state == S_FIN))
    else $error("result overwritten while still waiting");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && res_valid && state != S_FIN) |=> !res_valid)
    else $error("result word not removed after pop");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE && !q_empty))
    else $error("queue read outside idle");
`endif

endmodule

@@ src/mandelbrot_escape_color_unit.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_color_unit
// Escape-time evaluator for one point c, with a 3-bit color band.
// ----------------------------------------------------------------------------
// Input side is a queue: present c_re/c_im (Q4.28) with push; a word is taken
// when push is high and full is low. Result side is a one-word queue: while
// empty is low, iteration_count and color_code show the result; pop takes it.
// The cfg channel (cfg_valid/cfg_ready, always ready) writes max_iterations,
// 2000 after reset; write it only while no point is in flight.
// An input register feeds a four-word queue, which feeds the iteration engine.
// In the engine each iteration has a multiply state for the three products
// on 33-bit operands and an add state for the escape test and the update of z.
// The engine takes the next point, if one is queued, in the cycle after it
// writes a result; points are worked one at a time in arrival order. The
// input register cannot take a word while it still holds one: full rises in
// the cycle after each accepted word and stays high until the queue takes it.
// While the result waits for pop the engine holds its finished point and the
// input queue keeps taking words until it fills, then full stays high.
// Synchronous reset empties both queues and restores the iteration limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_color_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [mec_pkg::C_W-1:0]        c_re,
  input  logic signed [mec_pkg::C_W-1:0]        c_im,
  output logic                                  empty,
  input  logic                                  pop,
  output logic        [mec_pkg::CLR_W-1:0]      color_code,
  output logic        [mec_pkg::CNT_W-1:0]      iteration_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [mec_pkg::CNT_W-1:0]      cfg_data
);

  logic [mec_pkg::CNT_W-1:0] max_iterations;
  logic                      work_valid;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;
  mec_pkg::work_t            work_in;
  mec_pkg::work_t            work_out;

  mec_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .c_re           (c_re),
    .c_im           (c_im),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .max_iterations (max_iterations),
    .work_valid     (work_valid),
    .work_full      (q_full),
    .work           (work_in)
  );

  mec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (work_valid),
    .q_full  (q_full),
    .wr_data (work_in),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_data (work_out)
  );

  mec_core u_core (
    .clk             (clk),
    .rst             (rst),
    .max_iterations  (max_iterations),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .work            (work_out),
    .empty           (empty),
    .pop             (pop),
    .color_code      (color_code),
    .iteration_count (iteration_count)
  );

endmodule

@@ tb/mandelbrot_escape_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_checker
// Watches the point, result and cfg channels of the escape color unit. Every
// accepted point is run through a fixed-point escape-time model under the
// current iteration limit. Every popped word is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module mandelbrot_escape_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 full,
  input  logic signed [mec_pkg::C_W-1:0]       c_re,
  input  logic signed [mec_pkg::C_W-1:0]       c_im,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic        [mec_pkg::CLR_W-1:0]     color_code,
  input  logic        [mec_pkg::CNT_W-1:0]     iteration_count,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic        [mec_pkg::CNT_W-1:0]     cfg_data,
  output int                                   errors,
  output int                                   outstanding
);

  typedef struct packed {
    logic [mec_pkg::CLR_W-1:0] color;
    logic [mec_pkg::CNT_W-1:0] count;
  } escape_word_t;

  localparam logic signed [63:0] RADIUS_SQ = 64'sd1 <<< (mec_pkg::FRAC_BITS + 2);

  escape_word_t              predicted_escapes[$];
  logic [mec_pkg::CNT_W-1:0] iter_limit = mec_pkg::MAX_ITER_RESET;
  int                        err_tally  = 0;
  int                        words_seen = 0;

  // exact product, then floor division by 2^FRAC_BITS
  function automatic logic signed [63:0] fixed_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] wide;
    wa   = a;
    wb   = b;
    wide = wa * wb;
    return wide[mec_pkg::FRAC_BITS +: 64];
  endfunction

  function automatic logic [mec_pkg::CNT_W-1:0] escape_iterations(
    input logic signed [mec_pkg::C_W-1:0]   cre,
    input logic signed [mec_pkg::C_W-1:0]   cim,
    input logic        [mec_pkg::CNT_W-1:0] limit
  );
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] xx;
    logic signed [63:0] yy;
    logic signed [63:0] ny;
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    int                 n;
    bit                 escaped;
    cr      = cre;
    ci      = cim;
    x       = '0;
    y       = '0;
    n       = 0;
    escaped = 1'b0;
    while (n < limit && !escaped) begin
      xx = fixed_mul(x, x);
      yy = fixed_mul(y, y);
      if (xx + yy >= RADIUS_SQ) begin
        escaped = 1'b1;
      end else begin
        ny = fixed_mul(x + x, y) + ci;
        x  = xx - yy + cr;
        y  = ny;
        n++;
      end
    end
    return n[mec_pkg::CNT_W-1:0];
  endfunction

  // hues repeat red, yellow, green, cyan, magenta, blue
  function automatic logic [mec_pkg::CLR_W-1:0] hue_step(input int k);
    case (k % 6)
      0:       return mec_pkg::CLR_RED;
      1:       return mec_pkg::CLR_YELLOW;
      2:       return mec_pkg::CLR_GREEN;
      3:       return mec_pkg::CLR_CYAN;
      4:       return mec_pkg::CLR_MAGENTA;
      default: return mec_pkg::CLR_BLUE;
    endcase
  endfunction

  function automatic logic [mec_pkg::CLR_W-1:0] band_of(input logic [mec_pkg::CNT_W-1:0] n);
    int k;
    k = n;
    if (k < 5)         return mec_pkg::CLR_BLUE;
    else if (k < 20)   return hue_step((k - 5) / 5);
    else if (k < 50)   return hue_step(3 + (k - 20) / 10);
    else if (k < 1700) return hue_step(k / 100);
    else if (k < 1800) return mec_pkg::CLR_WHITE;
    else               return mec_pkg::CLR_BLACK;
  endfunction

  always @(posedge clk) begin
    escape_word_t want;
    if (rst) begin
      iter_limit = mec_pkg::MAX_ITER_RESET;
      predicted_escapes.delete();
    end else begin
      if (pop && !empty) begin
        words_seen++;
        if (predicted_escapes.size() == 0) begin
          if (err_tally < 10) begin
            $display("unexpected result word %0d: color %0d count %0d", words_seen,
                     color_code, iteration_count);
          end
          err_tally++;
        end else begin
          want = predicted_escapes.pop_front();
          if (color_code !== want.color || iteration_count !== want.count) begin
            if (err_tally < 10) begin
              $display({"mismatch on result word %0d: expected color %0d count %0d,",
                        " got color %0d count %0d"},
                       words_seen, want.color, want.count, color_code, iteration_count);
            end
            err_tally++;
          end
        end
      end
      if (push && !full) begin
        want.count = escape_iterations(c_re, c_im, iter_limit);
        want.color = band_of(want.count);
        predicted_escapes.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        iter_limit = cfg_data;
      end
    end
    errors      <= err_tally;
    outstanding <= predicted_escapes.size();
  end

endmodule

@@ tb/tb_mandelbrot_escape_color_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_color_unit
// Drives points and iteration limits into the escape color unit and pops its
// results. Directed points hit the field extremes, the escape boundary,
// points that never escape and the zero, white and black limit cases; random
// phases follow with fresh limits, random idling on both sides and one long
// result-side stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_color_unit;

  localparam logic signed [mec_pkg::C_W-1:0] Q_ONE = 32'sh1000_0000;
  localparam logic signed [mec_pkg::C_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [mec_pkg::C_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam int                             STALL_CYCLES  = 500;
  localparam int                             RANDOM_POINTS = 270;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             push      = 1'b0;
  logic signed [mec_pkg::C_W-1:0]   c_re      = '0;
  logic signed [mec_pkg::C_W-1:0]   c_im      = '0;
  logic                             pop       = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic        [mec_pkg::CNT_W-1:0] cfg_data  = '0;
  logic                             full;
  logic                             empty;
  logic                             cfg_ready;
  logic        [mec_pkg::CLR_W-1:0] color_code;
  logic        [mec_pkg::CNT_W-1:0] iteration_count;
  int                               errors;
  int                               outstanding;

  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit hold_request = 1'b0;

  always #10 clk = ~clk;

  mandelbrot_escape_color_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .c_re            (c_re),
    .c_im            (c_im),
    .empty           (empty),
    .pop             (pop),
    .color_code      (color_code),
    .iteration_count (iteration_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  mandelbrot_escape_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .c_re            (c_re),
    .c_im            (c_im),
    .empty           (empty),
    .pop             (pop),
    .color_code      (color_code),
    .iteration_count (iteration_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .outstanding     (outstanding)
  );

  task automatic send_point(input logic signed [mec_pkg::C_W-1:0] re,
                            input logic signed [mec_pkg::C_W-1:0] im);
    c_re <= re;
    c_im <= im;
    push <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  task automatic sender_gap();
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [mec_pkg::CNT_W-1:0] limit);
    wait_drained();
    cfg_data  <= limit;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // full range mostly escapes at once; the region around the set runs long
  task automatic send_random_point(input logic [mec_pkg::CNT_W-1:0] limit);
    logic signed [mec_pkg::C_W-1:0] re;
    logic signed [mec_pkg::C_W-1:0] im;
    int                             pick;
    int                             near_odds;
    near_odds = (limit <= 300) ? 60 : 15;
    pick      = $urandom_range(0, 99);
    if (pick < near_odds) begin
      re = $signed($urandom_range(0, 32'd3 << 28)) - 32'sd603979776;
      im = $signed($urandom_range(0, 32'd3 << 28)) - 32'sd402653184;
    end else if (pick < near_odds + 20) begin
      re = $signed($urandom_range(0, 32'd5 << 28)) - 32'sd671088640;
      im = $signed($urandom_range(0, 32'd5 << 28)) - 32'sd671088640;
    end else begin
      re = $urandom;
      im = $urandom;
    end
    send_point(re, im);
    sender_gap();
  endtask

  initial begin
    bit stall_done;
    stall_done = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request && !stall_done) begin
        stall_done = 1'b1;
        pop <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [mec_pkg::CNT_W-1:0] limit;
    int                        random_sent;
    int                        phase;
    int                        count;
    int                        r;
    random_sent = 0;
    phase       = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limit of 2000
    send_point('0, '0);
    send_point(Q_MIN, Q_MIN);
    send_point(Q_MAX, Q_MAX);
    sender_gap();
    send_point(Q_MAX, Q_MIN);
    send_point(Q_MIN, Q_MAX);
    send_point(-Q_ONE, '0);
    send_point(2 * Q_ONE, '0);
    sender_gap();
    send_point(-2 * Q_ONE, '0);
    send_point(32'sh0400_0000, '0);
    send_point(32'sh0428_F5C2, '0);
    send_point(-32'sh0C00_0000, 32'sh0199_999A);
    send_point('0, Q_ONE);
    send_point(32'sh04CC_CCCD, 32'sh0800_0000);

    write_limit('0);
    send_point('0, '0);
    send_point(Q_MAX, Q_MIN);
    send_point(-Q_ONE, Q_ONE);

    write_limit('1);
    send_point('0, '0);
    send_point(32'sh0428_F5C2, '0);

    write_limit(mec_pkg::CNT_W'(1799));
    send_point('0, '0);
    write_limit(mec_pkg::CNT_W'(1800));
    send_point('0, '0);

    while (random_sent < RANDOM_POINTS) begin
      phase++;
      if (random_sent >= RANDOM_POINTS - 40) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (phase == 2) begin
        // results back up behind a long pop stall until full rises
        write_limit(mec_pkg::CNT_W'(40));
        hold_request = 1'b1;
        repeat (16) begin
          send_point($urandom, $urandom);
        end
        random_sent += 16;
      end else begin
        r = $urandom_range(0, 9);
        if (r <= 5)      limit = mec_pkg::CNT_W'($urandom_range(0, 300));
        else if (r <= 7) limit = mec_pkg::CNT_W'($urandom_range(301, 1900));
        else if (r == 8) limit = mec_pkg::CNT_W'($urandom_range(1901, 4095));
        else             limit = ($urandom_range(0, 1) == 0) ? '0 : '1;
        write_limit(limit);
        count = $urandom_range(15, 35);
        repeat (count) begin
          send_random_point(limit);
        end
        random_sent += count;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
src/mec_pkg.sv
src/mec_front.sv
src/mec_queue.sv
src/mec_core.sv
src/mandelbrot_escape_color_unit.sv
tb/mandelbrot_escape_checker.sv
tb/tb_mandelbrot_escape_color_unit.sv
